### rtl/mpbs_pkg.sv
// ---------------------------------------------------------------------------
// mpbs_pkg : shared types and constants
// Sizes, request codes and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
package mpbs_pkg;
    localparam int CAPACITY = 1024;
    localparam int AW       = 10;   // address bits into the store
    localparam int LW       = 11;   // length, count and rank bits
    localparam int VW       = 11;   // value bits
    localparam int BW       = 32;   // budget bits

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TAKE = 1'b1;

    typedef struct packed {
        logic load;     // load accepted this cycle
        logic take;     // take accepted this cycle
        logic rd;       // issue store read at scan index
        logic eval;     // evaluate read data
        logic kill;     // remove chosen entry, charge budget
        logic emit;     // write the output register
    } t_cmd;

    typedef struct packed {
        logic empty;    // no live entries at take
        logic done;     // scan finishes with this evaluation
        logic out_free; // output register can take a result
    } t_sts;
endpackage

### rtl/max_permutation_bounded_swaps_core.sv
// ---------------------------------------------------------------------------
// max_permutation_bounded_swaps_core : largest permutation under swap budget
// Loads values into a store, then emits the greedy best value per take.
// ---------------------------------------------------------------------------
// Load: no result; the next request can be accepted in the following cycle.
// Take: a read state and an evaluate state per store entry scanned (registered
// store read), then removal and output, which can stall; an empty take goes straight to output.
// The scan of the single-port store sets the take time.
// Reset (synchronous, active low) clears control state; the store needs no
// clearing pass, the fill count marks what is valid.
module max_permutation_bounded_swaps_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mpbs_pkg::BW-1:0]     i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_req_type,
    input  logic [mpbs_pkg::VW-1:0]     i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mpbs_pkg::VW-1:0]     o_out_value,
    output logic [mpbs_pkg::BW-1:0]     o_budget_left,
    output logic                        o_is_last,
    output logic                        o_status
);
    mpbs_pkg::t_cmd cmd;
    mpbs_pkg::t_sts sts;

    mpbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_ready    (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mpbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_value   (o_out_value),
        .o_budget_left (o_budget_left),
        .o_is_last     (o_is_last),
        .o_status      (o_status)
    );
endmodule

### rtl/mpbs_ctrl.sv
// ---------------------------------------------------------------------------
// mpbs_ctrl : sequencing controller
// Accepts loads in idle; steps a take through scan, removal and output (an empty take goes straight to output).
// ---------------------------------------------------------------------------
module mpbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_req_type,
    output logic            o_ready,
    input  mpbs_pkg::t_sts  i_sts,
    output mpbs_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_KILL = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_req_type == mpbs_pkg::REQ_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.take = 1'b1;
                        n_state = i_sts.empty ? S_EMIT : S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.done ? S_KILL : S_RD;
            end
            S_KILL: begin
                o_cmd.kill = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### rtl/mpbs_dp.sv
// ---------------------------------------------------------------------------
// mpbs_dp : datapath
// Value store with live bits, scan registers, budget and output register.
// ---------------------------------------------------------------------------
module mpbs_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mpbs_pkg::BW-1:0]     i_cfg_data,
    input  logic [mpbs_pkg::VW-1:0]     i_value,
    input  mpbs_pkg::t_cmd              i_cmd,
    output mpbs_pkg::t_sts              o_sts,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mpbs_pkg::VW-1:0]     o_out_value,
    output logic [mpbs_pkg::BW-1:0]     o_budget_left,
    output logic                        o_is_last,
    output logic                        o_status
);
    // store word: {live, value}
    logic [mpbs_pkg::VW:0]      mem [mpbs_pkg::CAPACITY];
    logic [mpbs_pkg::VW:0]      r_rd;

    logic [mpbs_pkg::BW-1:0]    r_swap, r_budget, eff_budget;
    logic                       r_phase, r_empty;
    logic [mpbs_pkg::LW-1:0]    r_len, r_live, r_idx, r_rank, r_win, r_brank;
    logic [mpbs_pkg::LW-1:0]    rank_inc, idx_inc;
    logic [mpbs_pkg::VW-1:0]    r_bval;
    logic [mpbs_pkg::AW-1:0]    r_bpos;
    logic                       r_found;
    logic                       r_ov;
    logic [mpbs_pkg::BW:0]      bud_p1;
    logic                       wr_en;
    logic [mpbs_pkg::AW-1:0]    wr_addr;
    logic [mpbs_pkg::VW:0]      wr_data;
    logic                       ld_ok;
    logic                       rd_live, better;

    assign eff_budget = r_phase ? r_budget : r_swap;
    assign bud_p1     = {1'b0, eff_budget} + {{mpbs_pkg::BW{1'b0}}, 1'b1};
    assign ld_ok      = r_phase || (r_len < mpbs_pkg::LW'(mpbs_pkg::CAPACITY));
    assign rank_inc   = r_rank + mpbs_pkg::LW'(1);
    assign idx_inc    = r_idx + mpbs_pkg::LW'(1);
    assign rd_live    = r_rd[mpbs_pkg::VW];
    assign better     = !r_found || (r_rd[mpbs_pkg::VW-1:0] > r_bval);

    assign o_sts.empty    = r_phase ? (r_live == '0) : (r_len == '0);
    assign o_sts.done     = (rd_live && (rank_inc >= r_win)) || (idx_inc == r_len);
    assign o_sts.out_free = !r_ov || i_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_bpos;
        wr_data = '0;
        if (i_cmd.load && ld_ok) begin
            wr_en   = 1'b1;
            wr_addr = r_phase ? '0 : r_len[mpbs_pkg::AW-1:0];
            wr_data = {1'b1, i_value};
        end else if (i_cmd.kill) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx[mpbs_pkg::AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap   <= '0;
            r_budget <= '0;
            r_phase  <= 1'b0;
            r_len    <= '0;
            r_live   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_swap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                // a load after taking starts a new sequence
                r_phase <= 1'b0;
                if (r_phase) begin
                    r_len  <= mpbs_pkg::LW'(1);
                    r_live <= mpbs_pkg::LW'(1);
                end else if (ld_ok) begin
                    r_len  <= r_len + mpbs_pkg::LW'(1);
                    r_live <= r_live + mpbs_pkg::LW'(1);
                end
            end
            if (i_cmd.take) begin
                r_phase  <= 1'b1;
                r_budget <= eff_budget;
                if (!r_phase) begin
                    r_live <= r_len;
                end
            end
            if (i_cmd.kill) begin
                r_budget <= r_budget - {{(mpbs_pkg::BW-mpbs_pkg::LW){1'b0}},
                                        r_brank - mpbs_pkg::LW'(1)};
                r_live   <= r_live - mpbs_pkg::LW'(1);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_empty <= o_sts.empty;
            r_idx   <= '0;
            r_rank  <= '0;
            r_found <= 1'b0;
            r_bval  <= '0;
            r_brank <= '0;
            r_bpos  <= '0;
            if (bud_p1 > {{(mpbs_pkg::BW+1-mpbs_pkg::LW){1'b0}},
                          (r_phase ? r_live : r_len)}) begin
                r_win <= r_phase ? r_live : r_len;
            end else begin
                r_win <= bud_p1[mpbs_pkg::LW-1:0];
            end
        end
        if (i_cmd.eval) begin
            r_idx <= idx_inc;
            if (rd_live) begin
                r_rank <= rank_inc;
                if (better) begin
                    r_found <= 1'b1;
                    r_bval  <= r_rd[mpbs_pkg::VW-1:0];
                    r_brank <= rank_inc;
                    r_bpos  <= r_idx[mpbs_pkg::AW-1:0];
                end
            end
        end
        if (i_cmd.emit) begin
            o_out_value   <= r_empty ? '0 : r_bval;
            o_budget_left <= r_budget;
            o_is_last     <= !r_empty && (r_live == '0);
            o_status      <= r_empty;
        end
    end

    assign o_valid = r_ov;
endmodule

### rtl/mpbs_checker.sv
// ---------------------------------------------------------------------------
// mpbs_checker : port-level assertions
// Checks the handshakes and result consistency seen at the top level.
// ---------------------------------------------------------------------------
module mpbs_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     i_req_type,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [mpbs_pkg::VW-1:0]  o_out_value,
    input logic [mpbs_pkg::BW-1:0]  o_budget_left,
    input logic                     o_is_last,
    input logic                     o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_budget_left))
        else $error("output transaction dropped or changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_out_value == '0 && !o_is_last)
        else $error("empty take carries a value or last flag");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_req_type == mpbs_pkg::REQ_TAKE |=> !o_ready)
        else $error("take accepted without going busy");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_req_type == mpbs_pkg::REQ_LOAD && !o_valid
        |=> !o_valid)
        else $error("load produced a result");
endmodule

bind max_permutation_bounded_swaps_core mpbs_checker u_mpbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_value   (o_out_value),
    .o_budget_left (o_budget_left),
    .o_is_last     (o_is_last),
    .o_status      (o_status)
);
